// ===== hdl/pid_line_follow_with_speed_ramp_defines.svh =====
// assertion macros for the line follow controller
// used by the top level only; needs clk_i and rst_ni in scope for PLF_ASSERT
`ifndef PID_LINE_FOLLOW_WITH_SPEED_RAMP_DEFINES_SVH
`define PID_LINE_FOLLOW_WITH_SPEED_RAMP_DEFINES_SVH
`ifndef SYNTHESIS
`define PLF_ASSERT_CLK(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("plf assertion failed");
`define PLF_ASSERT(name, prop) `PLF_ASSERT_CLK(name, clk_i, rst_ni, prop)
`else
`define PLF_ASSERT_CLK(name, clk, rstn, prop)
`define PLF_ASSERT(name, prop)
`endif
`endif

// ===== hdl/plf_pkg.sv =====
// shared types and constants for the line follow controller
// no dependencies
`default_nettype none
package plf_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int SUM_BITS    = 24;
  localparam int GAIN_W      = 24;
  localparam int TGT_W       = 8;
  localparam int STEP_W      = 7;
  localparam int PERIOD_W    = 6;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_ADDR_W  = 3;
  localparam int FRAC_BITS   = 16;
  localparam int TURN_LIM    = 100;

  localparam int ERR_W = SAMPLE_BITS + 1;
  localparam int DLT_W = ERR_W + 1;
  localparam int P_W   = GAIN_W + 1 + ERR_W;
  localparam int I_W   = GAIN_W + 1 + SUM_BITS;
  localparam int D_W   = GAIN_W + 1 + DLT_W;
  // integral term limit sits at 2^50
  localparam int ILIM_SHIFT = 50;
  localparam int TOT_W = ((I_W > ILIM_SHIFT + 1) ? I_W : ILIM_SHIFT + 1) + 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GRAY        = 3'd0,
    REG_P_GAIN      = 3'd1,
    REG_I_GAIN      = 3'd2,
    REG_D_GAIN      = 3'd3,
    REG_RAMP_STEP   = 3'd4,
    REG_RAMP_PERIOD = 3'd5
  } cfg_reg_e;

  localparam logic [SAMPLE_BITS-1:0] GRAY_RST   = SAMPLE_BITS'(512);
  localparam logic [GAIN_W-1:0]      P_GAIN_RST = GAIN_W'(121242);
  localparam logic [GAIN_W-1:0]      I_GAIN_RST = GAIN_W'(85);
  localparam logic [GAIN_W-1:0]      D_GAIN_RST = GAIN_W'(393216);
  localparam logic [STEP_W-1:0]      STEP_RST   = STEP_W'(2);
  localparam logic [PERIOD_W-1:0]    PERIOD_RST = PERIOD_W'(50);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] gray;
    logic [GAIN_W-1:0]      p_gain;
    logic [GAIN_W-1:0]      i_gain;
    logic [GAIN_W-1:0]      d_gain;
    logic [STEP_W-1:0]      ramp_step;
    logic [PERIOD_W-1:0]    ramp_period;
  } plf_cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]    err;
    logic signed [DLT_W-1:0]    dlt;
    logic signed [SUM_BITS-1:0] esum;
  } plf_err_t;

  typedef struct packed {
    logic signed [P_W-1:0] p;
    logic signed [I_W-1:0] i;
    logic signed [D_W-1:0] d;
  } plf_prod_t;

endpackage
`default_nettype wire

// ===== hdl/plf_ramp.sv =====
// forward speed ramp: sample counter and ramped forward command state
// depends on plf_pkg
`default_nettype none
module plf_ramp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              acc_i,
  input  wire logic signed [plf_pkg::TGT_W-1:0]  target_i,
  input  wire plf_pkg::plf_cfg_t                 cfg_i,
  output logic signed [plf_pkg::TGT_W-1:0]       fwd_o
);
  import plf_pkg::*;

  logic [PERIOD_W-1:0]     cnt_q, cnt_d, cnt_inc;
  logic signed [TGT_W-1:0] fwd_q, fwd_d, fwd_mv;
  logic signed [TGT_W:0]   gap;
  logic signed [TGT_W+1:0] up, dn, tgt_w;
  logic                    hit;

  always_comb begin
    cnt_inc = cnt_q + PERIOD_W'(1);
    hit     = (cnt_inc >= cfg_i.ramp_period);
    gap     = {target_i[TGT_W-1], target_i} - {fwd_q[TGT_W-1], fwd_q};
    tgt_w   = {{2{target_i[TGT_W-1]}}, target_i};
    up      = {{2{fwd_q[TGT_W-1]}}, fwd_q} + {3'b000, cfg_i.ramp_step};
    dn      = {{2{fwd_q[TGT_W-1]}}, fwd_q} - {3'b000, cfg_i.ramp_step};
    // step toward the target, never past it
    if (!gap[TGT_W]) begin
      fwd_mv = (up > tgt_w) ? target_i : up[TGT_W-1:0];
    end else begin
      fwd_mv = (dn < tgt_w) ? target_i : dn[TGT_W-1:0];
    end
    fwd_d = hit ? fwd_mv : fwd_q;
    cnt_d = hit ? '0 : cnt_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      fwd_q <= '0;
    end else if (acc_i) begin
      cnt_q <= cnt_d;
      fwd_q <= fwd_d;
    end
  end

  assign fwd_o = fwd_d;

endmodule
`default_nettype wire

// ===== hdl/plf_err.sv =====
// error, saturating integrator and derivative difference, with the first stage register
// depends on plf_pkg
`default_nettype none
module plf_err (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                acc_i,
  input  wire logic [plf_pkg::SAMPLE_BITS-1:0]     light_i,
  input  wire logic signed [plf_pkg::TGT_W-1:0]    target_i,
  input  wire logic [plf_pkg::SAMPLE_BITS-1:0]     gray_i,
  output plf_pkg::plf_err_t                        s1_o
);
  import plf_pkg::*;

  localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

  logic signed [SUM_BITS-1:0] esum_q, esum_d;
  logic signed [ERR_W-1:0]    last_q, err, light_s, gray_s;
  logic signed [SUM_BITS:0]   sum_w;
  logic signed [DLT_W-1:0]    dlt;
  logic                       pos;
  plf_err_t                   s1_q, s1_d;

  always_comb begin
    light_s = $signed({1'b0, light_i});
    gray_s  = $signed({1'b0, gray_i});
    pos     = ~target_i[TGT_W-1] & (|target_i[TGT_W-2:0]);
    err     = pos ? (gray_s - light_s) : (light_s - gray_s);
    sum_w   = $signed({esum_q[SUM_BITS-1], esum_q})
            + $signed({{(SUM_BITS+1-ERR_W){err[ERR_W-1]}}, err});
    // overflow when the two top bits disagree
    if (sum_w[SUM_BITS] != sum_w[SUM_BITS-1]) begin
      esum_d = sum_w[SUM_BITS] ? SUM_MIN : SUM_MAX;
    end else begin
      esum_d = sum_w[SUM_BITS-1:0];
    end
    dlt       = $signed({err[ERR_W-1], err}) - $signed({last_q[ERR_W-1], last_q});
    s1_d.err  = err;
    s1_d.dlt  = dlt;
    s1_d.esum = esum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esum_q <= '0;
      last_q <= '0;
    end else if (acc_i) begin
      esum_q <= esum_d;
      last_q <= err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_q <= s1_d;
    end
  end

  assign s1_o = s1_q;

endmodule
`default_nettype wire

// ===== hdl/plf_mult.sv =====
// gain multipliers: p, i and d products, registered
// depends on plf_pkg
`default_nettype none
module plf_mult (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire plf_pkg::plf_err_t  s1_i,
  input  wire plf_pkg::plf_cfg_t  cfg_i,
  output plf_pkg::plf_prod_t      prod_o
);
  import plf_pkg::*;

  logic signed [GAIN_W:0] pg, ig, dg;
  plf_prod_t              prod_q, prod_d;

  always_comb begin
    pg       = $signed({1'b0, cfg_i.p_gain});
    ig       = $signed({1'b0, cfg_i.i_gain});
    dg       = $signed({1'b0, cfg_i.d_gain});
    prod_d.p = pg * s1_i.err;
    prod_d.i = ig * s1_i.esum;
    prod_d.d = dg * s1_i.dlt;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

// ===== hdl/plf_out.sv =====
// integral clip, pid sum, truncating scale-down, negation and turn clamp into the result register
// depends on plf_pkg
`default_nettype none
module plf_out (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire plf_pkg::plf_prod_t                prod_i,
  output logic signed [plf_pkg::TGT_W-1:0]       turn_o
);
  import plf_pkg::*;

  localparam logic signed [TOT_W-1:0] ILIM_POS =
    {{(TOT_W-ILIM_SHIFT-1){1'b0}}, 1'b1, {ILIM_SHIFT{1'b0}}};
  localparam logic signed [TOT_W-1:0] ILIM_NEG = -ILIM_POS;
  localparam logic signed [TOT_W-1:0] BIAS =
    {{(TOT_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
  localparam logic signed [TOT_W-1:0] LIM_POS = TOT_W'(TURN_LIM);
  localparam logic signed [TOT_W-1:0] LIM_NEG = -LIM_POS;
  localparam logic signed [TGT_W-1:0] TURN_POS = TGT_W'(TURN_LIM);
  localparam logic signed [TGT_W-1:0] TURN_NEG = -TURN_POS;

  logic signed [TOT_W-1:0] iext, iclip, total, tb, qmag, qneg;
  logic signed [TGT_W-1:0] turn_q, turn_d;

  always_comb begin
    iext = TOT_W'(prod_i.i);
    if (iext > ILIM_POS) begin
      iclip = ILIM_POS;
    end else if (iext < ILIM_NEG) begin
      iclip = ILIM_NEG;
    end else begin
      iclip = iext;
    end
    total = TOT_W'(prod_i.p) + iclip + TOT_W'(prod_i.d);
    // truncate toward zero: bias negative sums before the shift
    tb   = total[TOT_W-1] ? (total + BIAS) : total;
    qmag = tb >>> FRAC_BITS;
    qneg = -qmag;
    if (qmag < LIM_NEG) begin
      turn_d = TURN_POS;
    end else if (qmag > LIM_POS) begin
      turn_d = TURN_NEG;
    end else begin
      turn_d = qneg[TGT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      turn_q <= turn_d;
    end
  end

  assign turn_o = turn_q;

endmodule
`default_nettype wire

// ===== hdl/pid_line_follow_with_speed_ramp.sv =====
// top level of the line follow steering controller with ramped forward speed
// depends on plf_pkg, plf_ramp, plf_err, plf_mult, plf_out and the defines header
//
//   channel  direction  handshake             payload
//   in       sink       in_valid_i/in_ready_o light_sample_i, target_speed_i
//   out      source     out_valid_o/out_ready_i forward_cmd_o, turn_cmd_o
//   cfg      sink       cfg_we_i              cfg_addr_i, cfg_wdata_i
//
// one transaction per cycle sustained while results are taken; each result is registered in every stage
// the three stages are error/integrator, gain multiply, sum and clamp
// a result not taken holds the whole pipeline, so in_ready_o drops with it
// reset clears the ramp, integrator and pipeline valids and loads default settings
`default_nettype none
`include "pid_line_follow_with_speed_ramp_defines.svh"
module pid_line_follow_with_speed_ramp (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic [plf_pkg::SAMPLE_BITS-1:0]       light_sample_i,
  input  wire logic signed [plf_pkg::TGT_W-1:0]      target_speed_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic signed [plf_pkg::TGT_W-1:0]           forward_cmd_o,
  output logic signed [plf_pkg::TGT_W-1:0]           turn_cmd_o,
  input  wire logic                                  cfg_we_i,
  input  wire logic [plf_pkg::CFG_ADDR_W-1:0]        cfg_addr_i,
  input  wire logic [plf_pkg::CFG_DATA_W-1:0]        cfg_wdata_i
);
  import plf_pkg::*;

  plf_cfg_t                cfg_q, cfg_d;
  logic                    adv, acc;
  logic                    s1_valid_q, s2_valid_q, s3_valid_q;
  logic signed [TGT_W-1:0] fwd_next, s1_fwd_q, s2_fwd_q, s3_fwd_q;
  plf_err_t                s1;
  plf_prod_t               prod;

  // settings registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_GRAY:        cfg_d.gray        = cfg_wdata_i[SAMPLE_BITS-1:0];
        REG_P_GAIN:      cfg_d.p_gain      = cfg_wdata_i[GAIN_W-1:0];
        REG_I_GAIN:      cfg_d.i_gain      = cfg_wdata_i[GAIN_W-1:0];
        REG_D_GAIN:      cfg_d.d_gain      = cfg_wdata_i[GAIN_W-1:0];
        REG_RAMP_STEP:   cfg_d.ramp_step   = cfg_wdata_i[STEP_W-1:0];
        REG_RAMP_PERIOD: cfg_d.ramp_period = cfg_wdata_i[PERIOD_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gray        <= GRAY_RST;
      cfg_q.p_gain      <= P_GAIN_RST;
      cfg_q.i_gain      <= I_GAIN_RST;
      cfg_q.d_gain      <= D_GAIN_RST;
      cfg_q.ramp_step   <= STEP_RST;
      cfg_q.ramp_period <= PERIOD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // pipeline moves whenever the result register is free or being taken
  assign adv        = ~s3_valid_q | out_ready_i;
  assign acc        = in_valid_i & adv;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= acc;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_fwd_q <= fwd_next;
    end
    if (adv) begin
      s2_fwd_q <= s1_fwd_q;
      s3_fwd_q <= s2_fwd_q;
    end
  end

  plf_ramp u_ramp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (acc),
    .target_i (target_speed_i),
    .cfg_i    (cfg_q),
    .fwd_o    (fwd_next)
  );

  plf_err u_err (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (acc),
    .light_i  (light_sample_i),
    .target_i (target_speed_i),
    .gray_i   (cfg_q.gray),
    .s1_o     (s1)
  );

  plf_mult u_mult (
    .clk_i  (clk_i),
    .en_i   (adv),
    .s1_i   (s1),
    .cfg_i  (cfg_q),
    .prod_o (prod)
  );

  plf_out u_out (
    .clk_i  (clk_i),
    .en_i   (adv),
    .prod_i (prod),
    .turn_o (turn_cmd_o)
  );

  assign out_valid_o   = s3_valid_q;
  assign forward_cmd_o = s3_fwd_q;

  `PLF_ASSERT(a_turn_range, out_valid_o |-> (turn_cmd_o <= 8'sd100 && turn_cmd_o >= -8'sd100))
  `PLF_ASSERT(a_acc_enters, in_valid_i && in_ready_o |=> s1_valid_q)
  `PLF_ASSERT(a_out_from_s2, $rose(out_valid_o) |-> $past(s2_valid_q))

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// testbench for the line follow steering controller with ramped forward speed
// streams light samples through valid/ready channels and checks every result transaction
// against a predictor of the ramp and PID kept here; depends on plf_pkg and the rtl only
`timescale 1ns / 1ps

module tb_top;
  import plf_pkg::*;

  localparam int IDLE_PCT        = 38;
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int SAT_UP_ITEMS    = 120;
  localparam int SAT_DOWN_ITEMS  = 120;
  localparam int MAX_REPORTS     = 10;

  localparam longint SUM_MAX   = (64'sd1 <<< (SUM_BITS - 1)) - 1;
  localparam longint ITERM_MAX = 64'sd1 <<< ILIM_SHIFT;

  typedef struct {
    logic [SAMPLE_BITS-1:0]  light;
    logic signed [TGT_W-1:0] target;
  } sample_t;

  typedef struct {
    logic signed [TGT_W-1:0] forward;
    logic signed [TGT_W-1:0] turn;
  } steer_t;

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    in_valid_i     = 1'b0;
  logic                    in_ready_o;
  logic [SAMPLE_BITS-1:0]  light_sample_i = '0;
  logic signed [TGT_W-1:0] target_speed_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i    = 1'b0;
  logic signed [TGT_W-1:0] forward_cmd_o;
  logic signed [TGT_W-1:0] turn_cmd_o;
  logic                    cfg_we_i       = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_addr_i     = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i    = '0;

  logic calm     = 1'b0;
  logic hold_req = 1'b0;

  sample_t sample_backlog[$];
  steer_t  steer_expected[$];
  int      steer_faults = 0;

  // predictor copy of settings and controller state
  plf_cfg_t            model_cfg = '{GRAY_RST, P_GAIN_RST, I_GAIN_RST, D_GAIN_RST,
                                     STEP_RST, PERIOD_RST};
  logic [PERIOD_W-1:0] ramp_count  = '0;
  longint              forward_now = 0;
  longint              error_sum   = 0;
  longint              last_error  = 0;

  pid_line_follow_with_speed_ramp dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .light_sample_i (light_sample_i),
    .target_speed_i (target_speed_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .forward_cmd_o  (forward_cmd_o),
    .turn_cmd_o     (turn_cmd_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic steer_t steer_predict(input sample_t s);
    longint target;
    longint light;
    longint gray;
    longint step;
    longint err;
    longint p_k;
    longint i_k;
    longint d_k;
    longint i_term;
    longint total;
    longint q;
    steer_t r;
    target = longint'(s.target);
    light  = longint'(s.light);
    gray   = longint'(model_cfg.gray);
    step   = longint'(model_cfg.ramp_step);
    p_k    = longint'(model_cfg.p_gain);
    i_k    = longint'(model_cfg.i_gain);
    d_k    = longint'(model_cfg.d_gain);

    ramp_count = ramp_count + 1'b1;
    if (ramp_count >= model_cfg.ramp_period) begin
      ramp_count = '0;
      if (target - forward_now >= 0) begin
        forward_now = forward_now + step;
        if (forward_now > target) forward_now = target;
      end else begin
        forward_now = forward_now - step;
        if (forward_now < target) forward_now = target;
      end
    end

    // polarity follows the sign of the target, zero counts as reverse
    err = (target > 0) ? gray - light : light - gray;

    error_sum = error_sum + err;
    if (error_sum > SUM_MAX) error_sum = SUM_MAX;
    if (error_sum < -SUM_MAX - 1) error_sum = -SUM_MAX - 1;

    i_term = i_k * error_sum;
    if (i_term > ITERM_MAX) i_term = ITERM_MAX;
    if (i_term < -ITERM_MAX) i_term = -ITERM_MAX;

    total = p_k * err + i_term + d_k * (err - last_error);
    last_error = err;

    // signed division truncates toward zero
    q = (-total) / 65536;
    if (q > TURN_LIM) q = longint'(TURN_LIM);
    if (q < -TURN_LIM) q = longint'(-TURN_LIM);

    r.forward = TGT_W'(forward_now);
    r.turn    = TGT_W'(q);
    return r;
  endfunction

  function automatic void queue_sample(input int light, input int target);
    sample_t s;
    s.light  = SAMPLE_BITS'(light);
    s.target = TGT_W'(target);
    sample_backlog.push_back(s);
  endfunction

  function automatic void note_fault(input string msg);
    steer_faults++;
    if (steer_faults <= MAX_REPORTS) $display("[%0t] %s", $time, msg);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(3))
      0:       return '0;
      1:       return {GAIN_W{1'b1}};
      2:       return CFG_DATA_W'($urandom_range(32'h3FFFF));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // only called with the controller idle, so the predictor may take the new values at once
  task automatic apply_settings(input logic [CFG_DATA_W-1:0] gray,
                                input logic [CFG_DATA_W-1:0] p_gain,
                                input logic [CFG_DATA_W-1:0] i_gain,
                                input logic [CFG_DATA_W-1:0] d_gain,
                                input logic [CFG_DATA_W-1:0] step,
                                input logic [CFG_DATA_W-1:0] period);
    logic [CFG_DATA_W-1:0] vals[6];
    cfg_reg_e              idx;
    vals = '{gray, p_gain, i_gain, d_gain, step, period};
    for (int k = 0; k <= int'(REG_RAMP_PERIOD); k++) begin
      idx = cfg_reg_e'(k);
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= idx;
      cfg_wdata_i <= vals[k];
      case (idx)
        REG_GRAY:        model_cfg.gray        = vals[k][SAMPLE_BITS-1:0];
        REG_P_GAIN:      model_cfg.p_gain      = vals[k][GAIN_W-1:0];
        REG_I_GAIN:      model_cfg.i_gain      = vals[k][GAIN_W-1:0];
        REG_D_GAIN:      model_cfg.d_gain      = vals[k][GAIN_W-1:0];
        REG_RAMP_STEP:   model_cfg.ramp_step   = vals[k][STEP_W-1:0];
        REG_RAMP_PERIOD: model_cfg.ramp_period = vals[k][PERIOD_W-1:0];
        default: ;
      endcase
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // sampled on the falling edge so the queues and valid have settled
  task automatic settle();
    do @(negedge clk_i);
    while (sample_backlog.size() != 0 || in_valid_i || steer_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : driver
    sample_t next_sample;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        steer_expected.push_back(steer_predict(sample_t'{light_sample_i, target_speed_i}));
      end
      if (sample_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        next_sample    = sample_backlog.pop_front();
        in_valid_i     <= 1'b1;
        light_sample_i <= next_sample.light;
        target_speed_i <= next_sample.target;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    int     hold_left;
    logic   hold_done;
    steer_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   = 0;
      hold_done   = 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (steer_expected.size() == 0) begin
          note_fault($sformatf("result with nothing expected: forward_cmd %0d turn_cmd %0d",
                               forward_cmd_o, turn_cmd_o));
        end else begin
          want = steer_expected.pop_front();
          if (forward_cmd_o !== want.forward)
            note_fault($sformatf("forward_cmd expected %0d got %0d",
                                 want.forward, forward_cmd_o));
          if (turn_cmd_o !== want.turn)
            note_fault($sformatf("turn_cmd expected %0d got %0d", want.turn, turn_cmd_o));
        end
      end
      // one long back-pressure stretch so the pipeline fills and stalls its input
      if (hold_req && !hold_done) begin
        hold_done   = 1'b1;
        hold_left   = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left   = hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    int quiet;
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int light;
    int target;
    int near;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: first sample, zero target, extremes of both fields
    queue_sample(512, 0);
    queue_sample(0, 100);
    queue_sample(1023, 100);
    queue_sample(0, -100);
    queue_sample(1023, -100);
    queue_sample(1023, 127);
    queue_sample(0, -128);
    queue_sample(0, 0);
    queue_sample(1023, 0);
    queue_sample(511, 1);
    queue_sample(513, -1);
    queue_sample(512, 100);
    settle();

    // full gains, biggest step, ramp update on every sample
    apply_settings(0, {GAIN_W{1'b1}}, {GAIN_W{1'b1}}, {GAIN_W{1'b1}}, 127, 0);
    queue_sample(1023, -128);
    queue_sample(0, 127);
    queue_sample(1023, 127);
    queue_sample(0, -128);
    queue_sample(0, 0);
    queue_sample(1023, 1);
    queue_sample(1023, -1);
    queue_sample(5, 100);
    queue_sample(700, -100);
    queue_sample(1023, 127);
    settle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) begin
        apply_settings(0, 0, 0, 0, 0, 1);
      end else if (ph == 1) begin
        apply_settings(1023, {GAIN_W{1'b1}}, {GAIN_W{1'b1}}, {GAIN_W{1'b1}}, 127, 63);
      end else begin
        apply_settings(CFG_DATA_W'($urandom_range(1023)), pick_gain(), pick_gain(),
                       pick_gain(),
                       ($urandom_range(3) == 0) ? CFG_DATA_W'(100)
                                                : CFG_DATA_W'($urandom_range(127)),
                       CFG_DATA_W'($urandom_range(63)));
      end
      if (ph == 2) hold_req <= 1'b1;
      calm <= (ph == 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        case ($urandom_range(9))
          0: light = 0;
          1: light = 1023;
          2, 3: begin
            near  = $urandom_range(16);
            light = int'(model_cfg.gray) + near - 8;
            if (light < 0) light = 0;
            if (light > 1023) light = 1023;
          end
          default: light = $urandom_range(1023);
        endcase
        case ($urandom_range(9))
          0: target = int'($urandom_range(255)) - 128;
          1: target = 0;
          default: target = int'($urandom_range(200)) - 100;
        endcase
        queue_sample(light, target);
      end
      settle();
    end

    // run the integrator up with full error, then back down the other way
    calm <= 1'b1;
    apply_settings(1023, 0, 1, 0, CFG_DATA_W'($urandom_range(1, 10)),
                   CFG_DATA_W'($urandom_range(1, 63)));
    for (int n = 0; n < SAT_UP_ITEMS; n++) begin
      queue_sample(0, $urandom_range(1, 127));
    end
    settle();
    apply_settings(1023, 24'h000100, 2, 24'h000800, CFG_DATA_W'($urandom_range(100)),
                   CFG_DATA_W'($urandom_range(63)));
    for (int n = 0; n < SAT_DOWN_ITEMS; n++) begin
      target = $urandom_range(128);
      queue_sample(0, -target);
    end
    settle();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (steer_faults == 0 && steer_expected.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== pid_line_follow_with_speed_ramp.f =====
+incdir+hdl
hdl/plf_pkg.sv
hdl/plf_ramp.sv
hdl/plf_err.sv
hdl/plf_mult.sv
hdl/plf_out.sv
hdl/pid_line_follow_with_speed_ramp.sv
sim/tb_top.sv
